### rtl/core/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the point set center and unit scale block.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned VERTEX_DEPTH = 64;
  localparam int unsigned POS_W        = 24;
  localparam int unsigned NORM_W       = 16;
  localparam int unsigned FRAC_SHIFT   = 14;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned SUM_W        = 30;
  localparam int unsigned MAG_W        = 24;
  localparam int unsigned SQ_W         = 48;
  localparam int unsigned SQ_IN_W      = 50;
  localparam int unsigned ROOT_W       = 25;
  localparam int unsigned DIV_NUM_W    = 38;
  localparam int unsigned DIV_DEN_W    = 25;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_point;
  } point_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
    logic                     final_result;
  } result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } coord_t;

  typedef struct packed {
    logic                    bank;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
  } desc_t;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_CGO  = 13'b0000000000010,
    ST_CWT  = 13'b0000000000100,
    ST_DRD  = 13'b0000000001000,
    ST_DLAT = 13'b0000000010000,
    ST_DMUL = 13'b0000000100000,
    ST_DSUM = 13'b0000001000000,
    ST_DSQ  = 13'b0000010000000,
    ST_NRD  = 13'b0000100000000,
    ST_NLAT = 13'b0001000000000,
    ST_NGO  = 13'b0010000000000,
    ST_NWT  = 13'b0100000000000,
    ST_NOUT = 13'b1000000000000
  } back_state_e;

endpackage

### rtl/core/psc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_front
// Takes points in, writes them to the current bank, keeps per-axis sums and
// closes a set on the last point or when the bank is full.
// ----------------------------------------------------------------------------
module psc_front #(
  parameter int unsigned VertexDepth = psc_pkg::VERTEX_DEPTH,
  parameter int unsigned IdxW        = (VertexDepth > 1) ? $clog2(VertexDepth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  psc_pkg::point_t  point_i,
  output logic             wr_en_o,
  output logic [IdxW:0]    wr_addr_o,
  output psc_pkg::coord_t  wr_data_o,
  output logic             desc_push_o,
  output psc_pkg::desc_t   desc_o
);
  import psc_pkg::*;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sx_q, sy_q, sz_q, sx_d, sy_d, sz_d;
  logic                    bank_q, bank_d;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W-1:0] nx, ny, nz;
  logic                    close;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign nx      = sx_q + SUM_W'(point_i.pos_x);
  assign ny      = sy_q + SUM_W'(point_i.pos_y);
  assign nz      = sz_q + SUM_W'(point_i.pos_z);
  assign close   = point_i.last_point || (cnt_inc == CNT_W'(VertexDepth));

  assign wr_en_o   = accept_i;
  assign wr_addr_o = {bank_q, cnt_q[IdxW-1:0]};
  assign wr_data_o = '{x: point_i.pos_x, y: point_i.pos_y, z: point_i.pos_z};

  assign desc_push_o = accept_i && close;
  assign desc_o      = '{bank: bank_q, cnt: cnt_inc, sum_x: nx, sum_y: ny, sum_z: nz};

  always_comb begin
    cnt_d  = cnt_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    sz_d   = sz_q;
    bank_d = bank_q;
    if (accept_i) begin
      if (close) begin
        cnt_d  = '0;
        sx_d   = '0;
        sy_d   = '0;
        sz_d   = '0;
        bank_d = ~bank_q;
      end else begin
        cnt_d = cnt_inc;
        sx_d  = nx;
        sy_d  = ny;
        sz_d  = nz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      sz_q   <= '0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      sz_q   <= sz_d;
      bank_q <= bank_d;
    end
  end

endmodule

### rtl/core/psc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_store
// Two-bank point memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module psc_store #(
  parameter int unsigned VertexDepth = psc_pkg::VERTEX_DEPTH,
  parameter int unsigned IdxW        = (VertexDepth > 1) ? $clog2(VertexDepth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IdxW:0]    wr_addr_i,
  input  psc_pkg::coord_t  wr_data_i,
  input  logic             rd_en_i,
  input  logic [IdxW:0]    rd_addr_i,
  output psc_pkg::coord_t  rd_data_o
);
  import psc_pkg::*;

  coord_t mem [2**(IdxW+1)];
  coord_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/core/psc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div #(
  parameter int unsigned NumW = psc_pkg::DIV_NUM_W,
  parameter int unsigned DenW = psc_pkg::DIV_DEN_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, quo_q;
  logic [DenW-1:0]  den_q, rem_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;
  logic [DenW:0]    rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/psc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_sqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module psc_sqrt #(
  parameter int unsigned InW   = psc_pkg::SQ_IN_W,
  parameter int unsigned RootW = InW / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [InW-1:0]   op_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned StepW = $clog2(RootW + 1);

  logic [InW-1:0]   op_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial;
  logic [RootW-1:0] root_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q, ge;

  assign rem_sh = {rem_q[RemW-3:0], op_q[InW-1:InW-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[InW-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/core/psc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_back
// Sequencer for one closed set: centroid, greatest distance pass, then the
// normalizing pass that emits one result per stored point.
// ----------------------------------------------------------------------------
module psc_back #(
  parameter int unsigned VertexDepth = psc_pkg::VERTEX_DEPTH,
  parameter int unsigned IdxW        = (VertexDepth > 1) ? $clog2(VertexDepth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  input  psc_pkg::desc_t   desc_i,
  output logic             desc_pop_o,
  output logic             rd_en_o,
  output logic [IdxW:0]    rd_addr_o,
  input  psc_pkg::coord_t  rd_data_i,
  input  logic             res_full_i,
  output logic             res_push_o,
  output psc_pkg::result_t res_o,
  output logic             set_done_o
);
  import psc_pkg::*;

  back_state_e             state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, idx_q;
  logic                    bank_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [POS_W-1:0] cen_q [3];
  logic [MAG_W-1:0]        mag_q [3];
  logic                    neg_q [3];
  logic [SQ_W-1:0]         sq_q  [3];
  logic signed [NORM_W-1:0] nq_q [3];
  logic [ROOT_W-1:0]       best_q;
  logic [1:0]              ax_q;

  logic                    div_start, div_done, sq_start, sq_done;
  logic [DIV_NUM_W-1:0]    div_num, div_quo;
  logic [DIV_DEN_W-1:0]    div_den;
  logic [SQ_IN_W-1:0]      sq_op;
  logic [ROOT_W-1:0]       root;
  logic [SUM_W-1:0]        sum_abs;
  logic signed [POS_W:0]   dv [3];
  logic signed [POS_W-1:0] pt [3];
  logic [POS_W:0]          dv_abs [3];
  logic [CNT_W-1:0]        idx_inc;
  logic                    last_idx;
  logic [POS_W-1:0]        cq;
  logic [NORM_W-1:0]       nq;

  assign idx_inc  = idx_q + CNT_W'(1);
  assign last_idx = (idx_inc == cnt_q);
  assign sum_abs  = sum_q[ax_q][SUM_W-1] ? SUM_W'(-sum_q[ax_q]) : SUM_W'(sum_q[ax_q]);
  assign cq       = div_quo[POS_W-1:0];
  assign nq       = div_quo[NORM_W-1:0];

  assign pt[0] = rd_data_i.x;
  assign pt[1] = rd_data_i.y;
  assign pt[2] = rd_data_i.z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dv[a]     = (POS_W+1)'(pt[a]) - (POS_W+1)'(cen_q[a]);
      dv_abs[a] = dv[a][POS_W] ? (POS_W+1)'(-dv[a]) : (POS_W+1)'(dv[a]);
    end
  end

  assign div_start = (state_q == ST_CGO) || (state_q == ST_NGO);
  assign div_num   = (state_q == ST_CGO) ? DIV_NUM_W'(sum_abs)
                                         : {mag_q[ax_q], FRAC_SHIFT'(0)};
  assign div_den   = (state_q == ST_CGO) ? DIV_DEN_W'(cnt_q) : best_q;
  assign sq_start  = (state_q == ST_DSUM);
  assign sq_op     = SQ_IN_W'(sq_q[0]) + SQ_IN_W'(sq_q[1]) + SQ_IN_W'(sq_q[2]);

  psc_div #(.NumW(DIV_NUM_W), .DenW(DIV_DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  psc_sqrt #(.InW(SQ_IN_W), .RootW(ROOT_W)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .op_i(sq_op), .done_o(sq_done), .root_o(root)
  );

  assign desc_pop_o = (state_q == ST_IDLE) && desc_valid_i;
  assign rd_en_o    = (state_q == ST_DRD) || (state_q == ST_NRD);
  assign rd_addr_o  = {bank_q, idx_q[IdxW-1:0]};
  assign res_push_o = (state_q == ST_NOUT) && !res_full_i;
  assign set_done_o = res_push_o && last_idx;
  assign res_o      = '{norm_x: nq_q[0], norm_y: nq_q[1], norm_z: nq_q[2],
                        degenerate: (best_q == '0), final_result: last_idx};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (desc_valid_i) state_d = ST_CGO;
      ST_CGO:  state_d = ST_CWT;
      ST_CWT: begin
        if (div_done) state_d = (ax_q == 2'd2) ? ST_DRD : ST_CGO;
      end
      ST_DRD:  state_d = ST_DLAT;
      ST_DLAT: state_d = ST_DMUL;
      ST_DMUL: state_d = ST_DSUM;
      ST_DSUM: state_d = ST_DSQ;
      ST_DSQ: begin
        if (sq_done) state_d = last_idx ? ST_NRD : ST_DRD;
      end
      ST_NRD:  state_d = ST_NLAT;
      ST_NLAT: state_d = ST_NGO;
      ST_NGO:  state_d = (best_q == '0) ? ST_NOUT : ST_NWT;
      ST_NWT: begin
        if (div_done) state_d = (ax_q == 2'd2) ? ST_NOUT : ST_NGO;
      end
      ST_NOUT: begin
        if (!res_full_i) state_d = last_idx ? ST_IDLE : ST_NRD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cnt_q    <= desc_i.cnt;
        bank_q   <= desc_i.bank;
        sum_q[0] <= desc_i.sum_x;
        sum_q[1] <= desc_i.sum_y;
        sum_q[2] <= desc_i.sum_z;
        ax_q     <= 2'd0;
        idx_q    <= '0;
        best_q   <= '0;
      end
      ST_CWT: begin
        if (div_done) begin
          cen_q[ax_q] <= sum_q[ax_q][SUM_W-1] ? -cq : cq;
          ax_q        <= ax_q + 2'd1;
        end
      end
      ST_DLAT, ST_NLAT: begin
        for (int a = 0; a < 3; a++) begin
          mag_q[a] <= dv_abs[a][MAG_W-1:0];
          neg_q[a] <= dv[a][POS_W];
        end
        ax_q <= 2'd0;
      end
      ST_DMUL: begin
        for (int a = 0; a < 3; a++) begin
          sq_q[a] <= mag_q[a] * mag_q[a];
        end
      end
      ST_DSQ: begin
        if (sq_done) begin
          if (root > best_q) best_q <= root;
          idx_q <= last_idx ? '0 : idx_inc;
        end
      end
      ST_NGO: begin
        if (best_q == '0) begin
          for (int a = 0; a < 3; a++) nq_q[a] <= '0;
        end
      end
      ST_NWT: begin
        if (div_done) begin
          nq_q[ax_q] <= neg_q[ax_q] ? -nq : nq;
          ax_q       <= ax_q + 2'd1;
        end
      end
      ST_NOUT: begin
        if (!res_full_i) idx_q <= idx_inc;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/point_set_center_and_unit_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_center_and_unit_scale
// Centers a loaded point set on its centroid and scales it by its greatest
// distance from the centroid.
// ----------------------------------------------------------------------------
// channel   handshake      payload     role
// input     push / full    point_i     one point, last_point closes the set
// result    empty / pop    result_o    one normalized point per stored point
//
// a point is taken when push is high and full is low; a closed set is then
// processed by the centroid divisions, the root pass and the normalizing
// divisions, on the shared bit-serial divider and the root unit.
// two store banks: a second set loads while the first is processed; full is
// high while two closed sets are outstanding. reset clears all control state.
// ----------------------------------------------------------------------------
module point_set_center_and_unit_scale #(
  parameter int unsigned VertexDepth = psc_pkg::VERTEX_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  psc_pkg::point_t  point_i,
  output logic             empty,
  input  logic             pop,
  output psc_pkg::result_t result_o
);
  import psc_pkg::*;

  localparam int unsigned IdxW = (VertexDepth > 1) ? $clog2(VertexDepth) : 1;

  logic            accept, wr_en, rd_en, desc_push, desc_pop, set_done;
  logic            res_push, oq_full;
  logic [IdxW:0]   wr_addr, rd_addr;
  coord_t          wr_data, rd_data;
  desc_t           desc_in;
  result_t         res;
  logic [1:0]      sets_q;

  desc_t           dq_mem [2];
  logic            dq_wp_q, dq_rp_q;
  logic [1:0]      dq_cnt_q;
  result_t         oq_mem [2];
  logic            oq_wp_q, oq_rp_q;
  logic [1:0]      oq_cnt_q;
  logic            opop;

  assign full   = (sets_q == 2'd2);
  assign accept = push && !full;

  psc_front #(.VertexDepth(VertexDepth), .IdxW(IdxW)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .point_i,
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .desc_push_o(desc_push), .desc_o(desc_in)
  );

  psc_store #(.VertexDepth(VertexDepth), .IdxW(IdxW)) u_store (
    .clk_i, .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data)
  );

  psc_back #(.VertexDepth(VertexDepth), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni, .desc_valid_i(dq_cnt_q != 2'd0), .desc_i(dq_mem[dq_rp_q]),
    .desc_pop_o(desc_pop), .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .res_full_i(oq_full), .res_push_o(res_push), .res_o(res), .set_done_o(set_done)
  );

  // closed sets that still own a bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sets_q <= '0;
    end else begin
      sets_q <= sets_q + 2'(desc_push) - 2'(set_done);
    end
  end

  // set queue between front and back
  always_ff @(posedge clk_i) begin
    if (desc_push) dq_mem[dq_wp_q] <= desc_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_wp_q  <= 1'b0;
      dq_rp_q  <= 1'b0;
      dq_cnt_q <= '0;
    end else begin
      if (desc_push) dq_wp_q <= ~dq_wp_q;
      if (desc_pop)  dq_rp_q <= ~dq_rp_q;
      dq_cnt_q <= dq_cnt_q + 2'(desc_push) - 2'(desc_pop);
    end
  end

  // result queue
  assign oq_full  = (oq_cnt_q == 2'd2);
  assign empty    = (oq_cnt_q == 2'd0);
  assign opop     = pop && !empty;
  assign result_o = oq_mem[oq_rp_q];

  always_ff @(posedge clk_i) begin
    if (res_push) oq_mem[oq_wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (res_push) oq_wp_q <= ~oq_wp_q;
      if (opop)     oq_rp_q <= ~oq_rp_q;
      oq_cnt_q <= oq_cnt_q + 2'(res_push) - 2'(opop);
    end
  end

endmodule

### rtl/core/psc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the point set center and unit scale block.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input psc_pkg::result_t result_o
);
  import psc_pkg::*;

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting");

  // degenerate items carry zero coordinates
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.degenerate) |->
      (result_o.norm_x == '0 && result_o.norm_y == '0 && result_o.norm_z == '0))
    else $error("degenerate item with nonzero coordinates");

  // coordinates stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.norm_x >= -16'sd16384 && result_o.norm_x <= 16'sd16384 &&
                result_o.norm_y >= -16'sd16384 && result_o.norm_y <= 16'sd16384 &&
                result_o.norm_z >= -16'sd16384 && result_o.norm_z <= 16'sd16384))
    else $error("normalized coordinate out of range");

  // full only rises after an accepted item, the one that closes a set
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

endmodule

bind point_set_center_and_unit_scale psc_checker u_psc_checker (.*);
